// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk edge outside reset.
`define BBPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define BBPQ_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/bbpq_pkg.sv =====
package bbpq_pkg;

    localparam int PRIO_REGS  = 6;
    localparam int CAP_BITS   = 20;
    localparam int SIZE_BITS  = 16;
    localparam int TOPIC_BITS = 3;
    localparam int PRIO_BITS  = 4;
    localparam int CNT_OUT    = 7;
    localparam int HDR_BYTES  = 64;
    localparam int MAX_PAYLOAD = 65471;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 20'd262144;
    // topic 5 down to topic 0
    localparam logic [PRIO_REGS-1:0][PRIO_BITS-1:0] PRIO_RESET =
        {4'd2, 4'd4, 4'd8, 4'd7, 4'd7, 4'd6};

    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 3'd0;
    // topic priorities follow at consecutive indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIO0    = 3'd1;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_MARK    = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_REMOVE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RD_PTR  = 2'd0,
        RD_INC  = 2'd1,
        RD_DEC  = 2'd2,
        RD_ZERO = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_COPY = 2'd0,
        WR_NEW  = 2'd1,
        WR_MARK = 2'd2
    } wr_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD  = 3'd0,
        PTR_CLR   = 3'd1,
        PTR_INC   = 3'd2,
        PTR_DEC   = 3'd3,
        PTR_COUNT = 3'd4
    } ptr_op_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        ptr_op_t ptr_op;
        logic    pos_set;
        logic    sub_bytes;
        logic    cnt_dec;
        logic    evict_inc;
        logic    commit_ins;
        logic    res_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    item_ok;
        logic    fits;
        logic    count_zero;
        logic    ptr_zero;
        logic    ptr_lt_count;
        logic    ptr_inc_lt_count;
        logic    ptr_gt_pos;
        logic    victim;
        logic    pos_adv;
    } status_t;

    function automatic logic [PRIO_BITS-1:0] prio_lookup(
        input logic [PRIO_REGS-1:0][PRIO_BITS-1:0] tbl,
        input logic [TOPIC_BITS-1:0]               topic
    );
        logic [PRIO_BITS-1:0] p;
        p = '0;
        for (int i = 0; i < PRIO_REGS; i++)
        begin
            if (topic == TOPIC_BITS'(i))
            begin
                p = tbl[i];
            end
        end
        return p;
    endfunction

endpackage

// ===== src/bbpq_ctrl.sv =====
module bbpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bbpq_pkg::status_t sts,
    output bbpq_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_FIT, S_SC_CHK, S_SC_EV, S_DROP, S_SH_CHK, S_SH_WR,
        S_PO_CHK, S_PO_EV, S_IN_CHK, S_IN_WR, S_AC_RD, S_AC_WR, S_RM_RD,
        S_FRONT, S_RES, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   evict_reg, evict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            evict_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            evict_reg <= evict_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        evict_next = evict_reg;
        cmd        = '0;
        cmd.rd_sel = bbpq_pkg::RD_PTR;
        cmd.wr_sel = bbpq_pkg::WR_COPY;
        cmd.ptr_op = bbpq_pkg::PTR_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.action) inside
                    bbpq_pkg::ACT_ENQUEUE:
                        state_next = sts.item_ok ? S_FIT : S_FRONT;
                    bbpq_pkg::ACT_MARK, bbpq_pkg::ACT_CLEAR:
                        state_next = sts.count_zero ? S_FRONT : S_AC_RD;
                    default:
                        state_next = sts.count_zero ? S_FRONT : S_RM_RD;
                endcase
            end
            S_FIT:
            begin
                if (sts.fits)
                begin
                    cmd.ptr_op = bbpq_pkg::PTR_CLR;
                    state_next = S_PO_CHK;
                end
                else
                begin
                    cmd.ptr_op = bbpq_pkg::PTR_COUNT;
                    state_next = S_SC_CHK;
                end
            end
            S_SC_CHK:
            begin
                if (sts.ptr_zero)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bbpq_pkg::RD_DEC;
                    cmd.ptr_op = bbpq_pkg::PTR_DEC;
                    state_next = S_SC_EV;
                end
            end
            S_SC_EV:
            begin
                if (sts.victim)
                begin
                    evict_next = 1'b1;
                    state_next = S_DROP;
                end
                else
                begin
                    state_next = S_SC_CHK;
                end
            end
            S_DROP:
            begin
                cmd.sub_bytes = 1'b1;
                state_next    = S_SH_CHK;
            end
            S_SH_CHK:
            begin
                if (sts.ptr_inc_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bbpq_pkg::RD_INC;
                    state_next = S_SH_WR;
                end
                else
                begin
                    cmd.cnt_dec   = 1'b1;
                    cmd.evict_inc = evict_reg;
                    state_next    = evict_reg ? S_FIT : S_FRONT;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bbpq_pkg::WR_COPY;
                cmd.ptr_op = bbpq_pkg::PTR_INC;
                state_next = S_SH_CHK;
            end
            S_PO_CHK:
            begin
                if (sts.ptr_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bbpq_pkg::RD_PTR;
                    state_next = S_PO_EV;
                end
                else
                begin
                    cmd.pos_set = 1'b1;
                    cmd.ptr_op  = bbpq_pkg::PTR_COUNT;
                    state_next  = S_IN_CHK;
                end
            end
            S_PO_EV:
            begin
                if (sts.pos_adv)
                begin
                    cmd.ptr_op = bbpq_pkg::PTR_INC;
                    state_next = S_PO_CHK;
                end
                else
                begin
                    cmd.pos_set = 1'b1;
                    cmd.ptr_op  = bbpq_pkg::PTR_COUNT;
                    state_next  = S_IN_CHK;
                end
            end
            S_IN_CHK:
            begin
                if (sts.ptr_gt_pos)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = bbpq_pkg::RD_DEC;
                    state_next = S_IN_WR;
                end
                else
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = bbpq_pkg::WR_NEW;
                    cmd.commit_ins = 1'b1;
                    state_next     = S_FRONT;
                end
            end
            S_IN_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bbpq_pkg::WR_COPY;
                cmd.ptr_op = bbpq_pkg::PTR_DEC;
                state_next = S_IN_CHK;
            end
            S_AC_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bbpq_pkg::RD_PTR;
                state_next = S_AC_WR;
            end
            S_AC_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bbpq_pkg::WR_MARK;
                state_next = S_FRONT;
            end
            S_RM_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bbpq_pkg::RD_PTR;
                evict_next = 1'b0;
                state_next = S_DROP;
            end
            S_FRONT:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bbpq_pkg::RD_ZERO;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bbpq_dp.sv =====
`include "assert_macros.svh"

module bbpq_dp #(
    parameter int DEPTH       = 64,
    parameter int TAG_BITS    = 16,
    parameter int TOPIC_COUNT = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bbpq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bbpq_pkg::CAP_BITS-1:0]       cfg_data,
    input  logic [1:0]                          in_action,
    input  logic [bbpq_pkg::TOPIC_BITS-1:0]     in_topic,
    input  logic [bbpq_pkg::SIZE_BITS-1:0]      in_payload,
    input  logic [TAG_BITS-1:0]                 in_tag,
    input  bbpq_pkg::cmd_t                      cmd,
    output bbpq_pkg::status_t                   sts,
    output logic                                res_accepted,
    output logic [bbpq_pkg::CNT_OUT-1:0]        res_evicted,
    output logic                                res_front_valid,
    output logic [TAG_BITS-1:0]                 res_front_tag,
    output logic [bbpq_pkg::TOPIC_BITS-1:0]     res_front_topic,
    output logic [bbpq_pkg::SIZE_BITS-1:0]      res_front_size,
    output logic                                res_front_busy,
    output logic [bbpq_pkg::CNT_OUT-1:0]        res_count,
    output logic [bbpq_pkg::CAP_BITS-1:0]       res_bytes
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SB = bbpq_pkg::SIZE_BITS;
    localparam int TB = bbpq_pkg::TOPIC_BITS;
    localparam int CB = bbpq_pkg::CAP_BITS;
    localparam int EW = 1 + SB + TB + TAG_BITS;

    // entry layout: {busy, size, topic, tag}
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    logic [CB-1:0] cap_reg;
    logic [bbpq_pkg::PRIO_REGS-1:0][bbpq_pkg::PRIO_BITS-1:0] prio_reg;

    bbpq_pkg::action_t      act_reg;
    logic [TB-1:0]          topic_reg;
    logic [SB-1:0]          payload_reg;
    logic [TAG_BITS-1:0]    tag_reg;

    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] count_reg;
    logic [CB-1:0] bytes_reg;
    logic [bbpq_pkg::CNT_OUT-1:0] evict_reg;
    logic          acc_reg;

    logic [CW-1:0]       raddr;
    logic [EW-1:0]       wdata;
    logic [SB-1:0]       item_size;
    logic [bbpq_pkg::PRIO_BITS-1:0] item_prio, rd_prio;
    logic                rd_busy;
    logic [SB-1:0]       rd_size;
    logic [TB-1:0]       rd_topic;
    logic [CB-1:0]       drop_bytes;

    assign rd_busy  = rdata_reg[EW-1];
    assign rd_size  = rdata_reg[EW-2 -: SB];
    assign rd_topic = rdata_reg[TAG_BITS +: TB];

    assign item_size = payload_reg + SB'(bbpq_pkg::HDR_BYTES);
    assign item_prio = bbpq_pkg::prio_lookup(prio_reg, topic_reg);
    assign rd_prio   = bbpq_pkg::prio_lookup(prio_reg, rd_topic);
    assign drop_bytes = (CB'(rd_size) < bytes_reg) ? CB'(rd_size) : bytes_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= bbpq_pkg::CAP_RESET;
            prio_reg <= bbpq_pkg::PRIO_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == bbpq_pkg::REG_CAPACITY)
            begin
                cap_reg <= cfg_data;
            end
            for (int i = 0; i < bbpq_pkg::PRIO_REGS; i++)
            begin
                if (cfg_index == bbpq_pkg::REG_PRIO0 + bbpq_pkg::CFG_IDX_BITS'(i))
                begin
                    prio_reg[i] <= cfg_data[bbpq_pkg::PRIO_BITS-1:0];
                end
            end
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= bbpq_pkg::action_t'(in_action);
            topic_reg   <= in_topic;
            payload_reg <= in_payload;
            tag_reg     <= in_tag;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            bbpq_pkg::RD_INC:  raddr = ptr_reg + CW'(1);
            bbpq_pkg::RD_DEC:  raddr = ptr_reg - CW'(1);
            bbpq_pkg::RD_ZERO: raddr = '0;
            default:           raddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            bbpq_pkg::WR_NEW:  wdata = {1'b0, item_size, topic_reg, tag_reg};
            bbpq_pkg::WR_MARK: wdata = {(act_reg == bbpq_pkg::ACT_MARK), rdata_reg[EW-2:0]};
            default:           wdata = rdata_reg;
        endcase
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[ptr_reg[AW-1:0]] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr[AW-1:0]];
        end
    end

    always_comb
    begin
        case (cmd.ptr_op)
            bbpq_pkg::PTR_CLR:   ptr_next = '0;
            bbpq_pkg::PTR_INC:   ptr_next = ptr_reg + CW'(1);
            bbpq_pkg::PTR_DEC:   ptr_next = ptr_reg - CW'(1);
            bbpq_pkg::PTR_COUNT: ptr_next = count_reg;
            default:             ptr_next = ptr_reg;
        endcase
        if (cmd.load)
        begin
            ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            bytes_reg <= '0;
            evict_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.pos_set)
            begin
                pos_reg <= ptr_reg;
            end
            if (cmd.load)
            begin
                evict_reg <= '0;
                acc_reg   <= 1'b0;
            end
            if (cmd.sub_bytes)
            begin
                bytes_reg <= bytes_reg - drop_bytes;
            end
            if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.evict_inc)
            begin
                evict_reg <= evict_reg + bbpq_pkg::CNT_OUT'(1);
            end
            if (cmd.commit_ins)
            begin
                count_reg <= count_reg + CW'(1);
                bytes_reg <= bytes_reg + CB'(item_size);
                acc_reg   <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_accepted    <= acc_reg;
            res_evicted     <= evict_reg;
            res_front_valid <= (count_reg != '0);
            res_front_tag   <= (count_reg != '0) ? rdata_reg[TAG_BITS-1:0] : '0;
            res_front_topic <= (count_reg != '0) ? rd_topic : '0;
            res_front_size  <= (count_reg != '0) ? rd_size : '0;
            res_front_busy  <= (count_reg != '0) ? rd_busy : 1'b0;
            res_count       <= bbpq_pkg::CNT_OUT'(count_reg);
            res_bytes       <= bytes_reg;
        end
    end

    always_comb
    begin
        sts.action       = act_reg;
        sts.item_ok      = (32'(topic_reg) < TOPIC_COUNT)
                         && (32'(payload_reg) <= bbpq_pkg::MAX_PAYLOAD)
                         && ((CB'(payload_reg) + CB'(bbpq_pkg::HDR_BYTES)) <= cap_reg);
        sts.fits         = ((CB+1)'(bytes_reg) + (CB+1)'(item_size) <= (CB+1)'(cap_reg))
                         && (count_reg < CW'(DEPTH));
        sts.count_zero   = (count_reg == '0);
        sts.ptr_zero     = (ptr_reg == '0);
        sts.ptr_lt_count = (ptr_reg < count_reg);
        sts.ptr_inc_lt_count = ((ptr_reg + CW'(1)) < count_reg);
        sts.ptr_gt_pos   = (ptr_reg > pos_reg);
        sts.victim       = !rd_busy && (rd_prio < item_prio);
        sts.pos_adv      = ((ptr_reg == '0) && rd_busy) || (rd_prio >= item_prio);
    end

    `BBPQ_NEVER(a_count_range, count_reg > CW'(DEPTH), "entry count above depth")
    `BBPQ_ASSERT(a_ins_grows, cmd.commit_ins |=> count_reg == $past(count_reg) + CW'(1), "no growth")
    `BBPQ_ASSERT(a_ins_room, cmd.commit_ins |-> count_reg < CW'(DEPTH), "insert into full store")

endmodule

// ===== src/byte_budget_priority_queue.sv =====
// Flow: a word is captured, then dispatched by action. Enqueue rejects a bad
//   item, evicts the rearmost idle lower-priority entry while the item does not
//   fit (rejecting it if none is left), then scans for its place and shifts
//   later entries up to insert it. Mark/clear set or clear the front busy flag;
//   remove drops the front entry. The front entry is then read into the result.
// Throughput: one item at a time; a new word is taken only once the last result is accepted.
// Reset: rst_n is asynchronous; counts, bytes, sequencer state and config registers
//   return to defaults; entry store, captured item and result registers are left as they are.
module byte_budget_priority_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16,
    parameter int TOPIC_COUNT = 6
) (
    input  logic clk,
    input  logic rst_n,
    // configuration: index 0 capacity, 1..6 topic priorities
    input  logic                              cfg_wr_en,
    input  logic [bbpq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [bbpq_pkg::CAP_BITS-1:0]     cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // action, topic, payload_bytes, packet_tag (low to high), zero padded
    input  logic [((2 + bbpq_pkg::TOPIC_BITS + bbpq_pkg::SIZE_BITS + TAG_BITS + 7) / 8) * 8
                  - 1:0]          s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted, evicted_count, front_valid, front_tag, front_topic,
    // front_size, front_busy, entry_count, byte total (low to high)
    output logic [((1 + bbpq_pkg::CNT_OUT + 1 + TAG_BITS + bbpq_pkg::TOPIC_BITS
                    + bbpq_pkg::SIZE_BITS + 1 + bbpq_pkg::CNT_OUT + bbpq_pkg::CAP_BITS
                    + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int OUT_RAW = 1 + bbpq_pkg::CNT_OUT + 1 + TAG_BITS + bbpq_pkg::TOPIC_BITS
                           + bbpq_pkg::SIZE_BITS + 1 + bbpq_pkg::CNT_OUT + bbpq_pkg::CAP_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    bbpq_pkg::cmd_t    cmd;
    bbpq_pkg::status_t sts;

    logic                              res_accepted;
    logic [bbpq_pkg::CNT_OUT-1:0]      res_evicted;
    logic                              res_front_valid;
    logic [TAG_BITS-1:0]               res_front_tag;
    logic [bbpq_pkg::TOPIC_BITS-1:0]   res_front_topic;
    logic [bbpq_pkg::SIZE_BITS-1:0]    res_front_size;
    logic                              res_front_busy;
    logic [bbpq_pkg::CNT_OUT-1:0]      res_count;
    logic [bbpq_pkg::CAP_BITS-1:0]     res_bytes;

    // Sequencer: one memory access per cycle, results held until taken.
    bbpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Entry store, counters and config registers.
    bbpq_dp #(
        .DEPTH       (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .TOPIC_COUNT (TOPIC_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_action       (s_axis_tdata[1:0]),
        .in_topic        (s_axis_tdata[2 +: bbpq_pkg::TOPIC_BITS]),
        .in_payload      (s_axis_tdata[5 +: bbpq_pkg::SIZE_BITS]),
        .in_tag          (s_axis_tdata[21 +: TAG_BITS]),
        .cmd             (cmd),
        .sts             (sts),
        .res_accepted    (res_accepted),
        .res_evicted     (res_evicted),
        .res_front_valid (res_front_valid),
        .res_front_tag   (res_front_tag),
        .res_front_topic (res_front_topic),
        .res_front_size  (res_front_size),
        .res_front_busy  (res_front_busy),
        .res_count       (res_count),
        .res_bytes       (res_bytes)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = OUT_W'({res_bytes, res_count, res_front_busy, res_front_size,
                                  res_front_topic, res_front_tag, res_front_valid,
                                  res_evicted, res_accepted});

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Block-level bench for the byte-budget priority queue.
// One word in gives exactly one result word out; a behavioral queue model
// predicts each result at the input handshake unless one is typed in; the output monitor
// compares field by field.
module tb_top;

    localparam int IN_W  = 40;   // 37 bits of fields, padded to 5 bytes
    localparam int OUT_W = 72;   // 72 bits of fields, already whole bytes

    // Result word; the last member sits in the lowest bits (accepted at bit 0).
    typedef struct packed {
        logic [19:0] held_total;
        logic [6:0]  entry_count;
        logic        front_busy;
        logic [15:0] front_size;
        logic [2:0]  front_topic;
        logic [15:0] front_tag;
        logic        front_valid;
        logic [6:0]  evicted_count;
        logic        accepted;
    } q_result_t;

    typedef struct {
        logic [15:0] tag;
        logic [2:0]  topic;
        logic [15:0] size;
        bit          busy;
    } slot_t;

    typedef struct {
        bbpq_pkg::action_t act;
        logic [2:0]  topic;
        logic [15:0] payload;
        logic [15:0] tag;
        bit          typed;      // result typed in by hand
        q_result_t   res;
    } vec_t;

    typedef struct {
        int unsigned cap;
        int unsigned prio [6];
        bit          rand_prio;
        int unsigned send_idle;
        int unsigned recv_stall;
        int unsigned enq_pct;
        int unsigned pay_max;
        int unsigned n_items;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [bbpq_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [bbpq_pkg::CAP_BITS-1:0]     cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // action, topic, payload_bytes, packet_tag (low to high), zero padded
    logic [IN_W-1:0]         s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // accepted, evicted_count, front_valid, front_tag, front_topic,
    // front_size, front_busy, entry_count, byte total (low to high)
    logic [OUT_W-1:0]        m_axis_tdata;

    byte_budget_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- queue model ----------------
    int unsigned cap_reg;
    logic [3:0]  prio_reg [6];
    slot_t       slots [$];
    int unsigned held_bytes;

    q_result_t   expected_results [$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    function automatic logic [3:0] topic_prio(logic [2:0] t);
        return (t < 3'd6) ? prio_reg[t] : 4'd0;
    endfunction

    function automatic void drop_slot(int idx);
        int unsigned sz;
        sz = slots[idx].size;
        held_bytes -= (sz < held_bytes) ? sz : held_bytes;
        slots.delete(idx);
    endfunction

    // Advance the model by one word and return the result it must produce.
    function automatic q_result_t queue_step(bbpq_pkg::action_t act, logic [2:0] topic,
                                             logic [15:0] payload, logic [15:0] tag);
        q_result_t   r;
        int unsigned sz;
        int unsigned evicted;
        int          pos;
        int          victim;
        logic [3:0]  pr;
        bit          ok;
        slot_t       e;
        r = '0;
        evicted = 0;
        ok = 1'b0;
        if (act == bbpq_pkg::ACT_ENQUEUE)
        begin
            sz = payload + bbpq_pkg::HDR_BYTES;
            // unknown topic, oversized payload and too big for the budget
            // are rejected with nothing evicted
            if (topic < 3'd6 && payload <= bbpq_pkg::MAX_PAYLOAD && sz <= cap_reg)
            begin
                pr = topic_prio(topic);
                ok = 1'b1;
                while (ok && (longint'(held_bytes) + sz > cap_reg || slots.size() >= 64))
                begin
                    victim = -1;
                    for (int k = slots.size() - 1; k >= 0 && victim < 0; k--)
                        if (!slots[k].busy && topic_prio(slots[k].topic) < pr)
                            victim = k;
                    if (victim < 0)
                        ok = 1'b0;   // evictions so far stand
                    else
                    begin
                        drop_slot(victim);
                        evicted++;
                    end
                end
                if (ok)
                begin
                    pos = 0;
                    if (slots.size() > 0 && slots[0].busy)
                        pos = 1;
                    while (pos < slots.size() && topic_prio(slots[pos].topic) >= pr)
                        pos++;
                    e.tag = tag;
                    e.topic = topic;
                    e.size = sz[15:0];
                    e.busy = 1'b0;
                    slots.insert(pos, e);
                    held_bytes = (held_bytes + sz) & 32'hFFFFF;
                end
            end
        end
        else if (slots.size() > 0)
        begin
            case (act)
                bbpq_pkg::ACT_MARK:  slots[0].busy = 1'b1;
                bbpq_pkg::ACT_CLEAR: slots[0].busy = 1'b0;
                default:             drop_slot(0);
            endcase
        end
        r.accepted = ok;
        r.evicted_count = evicted[6:0];
        if (slots.size() > 0)
        begin
            r.front_valid = 1'b1;
            r.front_tag   = slots[0].tag;
            r.front_topic = slots[0].topic;
            r.front_size  = slots[0].size;
            r.front_busy  = slots[0].busy;
        end
        r.entry_count = 7'(slots.size());
        r.held_total  = held_bytes[19:0];
        return r;
    endfunction

    // ---------------- drivers ----------------
    task automatic cfg_write(logic [bbpq_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[bbpq_pkg::CAP_BITS-1:0];
        @(posedge clk);
        if (idx == bbpq_pkg::REG_CAPACITY)
            cap_reg = val & 32'hFFFFF;
        else
            prio_reg[idx - bbpq_pkg::REG_PRIO0] = val[3:0];
    endtask

    // Send one word; model is stepped at the accepting edge.
    task automatic send_word(bbpq_pkg::action_t act, logic [2:0] topic, logic [15:0] payload,
                             logic [15:0] tag, bit typed, q_result_t typed_res);
        q_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, tag, payload, topic, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = queue_step(act, topic, payload, tag);
        expected_results = {expected_results, (typed ? typed_res : r)};
    endtask

    // Wait until every result is back, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver back-pressure.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        q_result_t got;
        q_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = q_result_t'(m_axis_tdata);
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_axis_tdata);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.accepted !== want.accepted
                    || got.evicted_count !== want.evicted_count
                    || got.front_valid !== want.front_valid
                    || got.front_tag !== want.front_tag
                    || got.front_topic !== want.front_topic
                    || got.front_size !== want.front_size
                    || got.front_busy !== want.front_busy
                    || got.entry_count !== want.entry_count
                    || got.held_total !== want.held_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: acc=%0d ev=%0d fv=%0d tag=%h top=%0d %s",
                                 want.accepted, want.evicted_count, want.front_valid,
                                 want.front_tag, want.front_topic,
                                 $sformatf("sz=%0d busy=%0d cnt=%0d bytes=%0d",
                                           want.front_size, want.front_busy,
                                           want.entry_count, want.held_total));
                        $display("mismatch got: acc=%0d ev=%0d fv=%0d tag=%h top=%0d %s",
                                 got.accepted, got.evicted_count, got.front_valid,
                                 got.front_tag, got.front_topic,
                                 $sformatf("sz=%0d busy=%0d cnt=%0d bytes=%0d",
                                           got.front_size, got.front_busy,
                                           got.entry_count, got.held_total));
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    vec_t   vecs [$];
    phase_t phases [$];

    function automatic void add_vec(vec_t v);
        vecs = {vecs, v};
    endfunction

    function automatic void add_phase(phase_t p);
        phases = {phases, p};
    endfunction

    function automatic vec_t mk_vec(bbpq_pkg::action_t act, logic [2:0] topic,
                                    logic [15:0] payload, logic [15:0] tag, bit typed);
        vec_t v;
        v.act = act;
        v.topic = topic;
        v.payload = payload;
        v.tag = tag;
        v.typed = typed;
        v.res = '0;
        return v;
    endfunction

    function automatic phase_t mk_phase(int unsigned cap, int unsigned p0, int unsigned p1,
                                        int unsigned p2, int unsigned p3, int unsigned p4,
                                        int unsigned p5, bit rp, int unsigned idle,
                                        int unsigned stall, int unsigned enq,
                                        int unsigned pmax, int unsigned n);
        phase_t p;
        p.cap = cap;
        p.prio = '{p0, p1, p2, p3, p4, p5};
        p.rand_prio = rp;
        p.send_idle = idle;
        p.recv_stall = stall;
        p.enq_pct = enq;
        p.pay_max = pmax;
        p.n_items = n;
        return p;
    endfunction

    initial
    begin
        vec_t              v;
        phase_t            ph;
        bbpq_pkg::action_t act;
        logic [2:0]        topic;
        logic [15:0]       payload;
        int unsigned       roll;

        cap_reg = bbpq_pkg::CAP_RESET;
        for (int i = 0; i < 6; i++)
            prio_reg[i] = bbpq_pkg::PRIO_RESET[i];
        held_bytes = 0;

        // Directed: empty-queue actions, rejects, extremes, every action.
        add_vec(mk_vec(bbpq_pkg::ACT_MARK,    3'd0, 16'd0,     16'h0000, 1'b1));
        add_vec(mk_vec(bbpq_pkg::ACT_REMOVE,  3'd0, 16'd0,     16'h0000, 1'b1));
        add_vec(mk_vec(bbpq_pkg::ACT_CLEAR,   3'd7, 16'hFFFF,  16'hFFFF, 1'b1));
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd6, 16'd10,    16'h1234, 1'b1)); // bad topic
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd7, 16'd0,     16'hFFFF, 1'b1));
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd0, 16'd65472, 16'h0001, 1'b1)); // oversized
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd3, 16'hFFFF,  16'h0002, 1'b1));
        v = mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd0, 16'd0, 16'h0000, 1'b1);
        v.res.accepted = 1'b1;
        v.res.front_valid = 1'b1;
        v.res.front_size = 16'd64;
        v.res.entry_count = 7'd1;
        v.res.held_total = 20'd64;
        add_vec(v);
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd3, 16'd65471, 16'hFFFF, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_MARK,    3'd0, 16'd0,     16'h0000, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd5, 16'd100,   16'hAAAA, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd1, 16'd200,   16'h5555, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd2, 16'd300,   16'h0F0F, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_ENQUEUE, 3'd4, 16'd1,     16'hF0F0, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_CLEAR,   3'd0, 16'd0,     16'h0000, 1'b0));
        add_vec(mk_vec(bbpq_pkg::ACT_MARK,    3'd0, 16'd0,     16'h0000, 1'b0));
        for (int i = 0; i < 7; i++)
            add_vec(mk_vec(bbpq_pkg::ACT_REMOVE, 3'd0, 16'd0, 16'h0000, 1'b0));

        // Random phases: capacity and priorities per phase, idling per phase.
        //             cap      priorities          rnd idle stall enq pmax   n
        add_phase(mk_phase(1048575, 6, 7, 7, 8, 4, 2, 0,  0,  0, 85, 200, 130));
        add_phase(mk_phase(2000,    0,15, 3, 9, 9, 1, 0, 60,  0, 60, 600, 110));
        add_phase(mk_phase(500,    15, 0, 7, 7, 2,15, 0,  0, 60, 60, 400, 110));
        add_phase(mk_phase(64,      1, 2, 3, 4, 5, 6, 0, 16, 16, 60,   2,  90));
        add_phase(mk_phase(0,       0, 0, 0, 0, 0, 0, 1,  0,  0, 50, 100,  40));
        add_phase(mk_phase(1,      15,15,15,15,15,15, 0, 16, 16, 50, 100,  40));
        add_phase(mk_phase(100000,  0, 0, 0, 0, 0, 0, 1, 16, 60, 65,65535,110));
        add_phase(mk_phase(1048575, 0, 0, 0, 0, 0, 0, 1, 60, 60, 80, 100, 160));
        // capacity lowered well below what the previous phase left held
        add_phase(mk_phase(3000,    0, 0, 0, 0, 0, 0, 1,  0,  0, 60, 300, 130));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vecs[i])
            send_word(vecs[i].act, vecs[i].topic, vecs[i].payload, vecs[i].tag,
                      vecs[i].typed, vecs[i].res);
        drain();

        foreach (phases[pi])
        begin
            ph = phases[pi];
            send_idle_pct = 0;
            cfg_write(bbpq_pkg::REG_CAPACITY, ph.cap);
            for (int t = 0; t < 6; t++)
                cfg_write(bbpq_pkg::REG_PRIO0 + t[bbpq_pkg::CFG_IDX_BITS-1:0],
                          ph.rand_prio ? $urandom_range(15) : ph.prio[t]);
            cfg_wr_en <= 1'b0;
            send_idle_pct = ph.send_idle;
            recv_stall_pct = ph.recv_stall;
            for (int n = 0; n < ph.n_items; n++)
            begin
                roll = $urandom_range(99);
                if (roll < ph.enq_pct)
                    act = bbpq_pkg::ACT_ENQUEUE;
                else
                    act = bbpq_pkg::action_t'(2'($urandom_range(3, 1)));
                topic = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(5));
                payload = ($urandom_range(15) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(ph.pay_max));
                send_word(act, topic, payload, 16'($urandom), 1'b0, '0);
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
